// File: sv/supersampled_shape_coverage_macros.svh
// ----------------------------------------------------------------------------
// supersampled shape coverage assertion macros
// shared property templates for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SUPERSAMPLED_SHAPE_COVERAGE_MACROS_SVH
`define SUPERSAMPLED_SHAPE_COVERAGE_MACROS_SVH

// same-cycle implication
`define SSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssc check failed");

// next-cycle implication
`define SSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssc check failed");

`endif

// File: sv/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// types, widths and codes shared by the shape coverage block
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int MAX_PRIM_DEF    = 16;
    localparam int SAMPLE_GRID_DEF = 8;
    localparam int FRAC_BITS_DEF   = 4;
    localparam int TABLE_SLOTS     = 16;

    localparam int IDX_W  = 4;
    localparam int KIND_W = 3;
    localparam int PT_W   = 16;
    localparam int LEN_W  = 17;
    localparam int COL_W  = 32;
    localparam int PIX_W  = 11;
    localparam int CNT_W  = 5;
    localparam int SQ_W   = 35;
    localparam int VW     = 36;
    localparam int ITER   = VW / 2;
    localparam int ITER_W = 5;

    localparam logic [KIND_W-1:0] KIND_STROKE_CIRCLE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINE          = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STROKE_RECT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FILL_CIRCLE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FILL_RECT     = 3'd4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_SQ,
        ST_LOAD_ROOT,
        ST_LOAD_WAIT,
        ST_SHADE,
        ST_DIV,
        ST_OUT
    } ssc_state_t;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         entry_index;
        logic [KIND_W-1:0]        shape_kind;
        logic signed [PT_W-1:0]   point_a_x;
        logic signed [PT_W-1:0]   point_a_y;
        logic signed [PT_W-1:0]   point_b_x;
        logic signed [PT_W-1:0]   point_b_y;
        logic [PT_W-1:0]          radius;
        logic [PT_W-1:0]          stroke_width;
        logic [COL_W-1:0]         colour;
        logic [LEN_W-1:0]         length;
    } ssc_wr_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] colour;
    } ssc_chain_t;

endpackage

`default_nettype wire

// File: sv/ssc_req_if.sv
// ----------------------------------------------------------------------------
// ssc_req_if
// command channel: load a table entry or shade one pixel
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_req_if import ssc_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [IDX_W-1:0]       entry_index;
    logic [KIND_W-1:0]      shape_kind;
    logic signed [PT_W-1:0] point_a_x;
    logic signed [PT_W-1:0] point_a_y;
    logic signed [PT_W-1:0] point_b_x;
    logic signed [PT_W-1:0] point_b_y;
    logic [PT_W-1:0]        radius;
    logic [PT_W-1:0]        stroke_width;
    logic [COL_W-1:0]       colour;
    logic [PIX_W-1:0]       pixel_x;
    logic [PIX_W-1:0]       pixel_y;

    modport source (
        output valid, command, entry_index, shape_kind, point_a_x, point_a_y,
               point_b_x, point_b_y, radius, stroke_width, colour, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, shape_kind, point_a_x, point_a_y,
               point_b_x, point_b_y, radius, stroke_width, colour, pixel_x, pixel_y,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/ssc_rsp_if.sv
// ----------------------------------------------------------------------------
// ssc_rsp_if
// result channel: one averaged pixel per shade item
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_rsp_if import ssc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_x;
    logic [PIX_W-1:0] out_y;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [7:0]       alpha;

    modport source (output valid, out_x, out_y, blue, green, red, alpha, input ready);
    modport sink (input valid, out_x, out_y, blue, green, red, alpha, output ready);
endinterface

`default_nettype wire

// File: sv/ssc_isqrt.sv
// ----------------------------------------------------------------------------
// ssc_isqrt
// iterative rounded square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_isqrt import ssc_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SQ_W-1:0]  value,
    output logic                  done,
    output logic [LEN_W-1:0]      root
);

    logic [VW-1:0]     n_reg, res_reg, bit_reg;
    logic [VW-1:0]     trial;
    logic [ITER_W-1:0] cnt_reg;
    logic              run_reg, done_reg;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = (n_reg > res_reg) ? LEN_W'(res_reg + VW'(1)) : LEN_W'(res_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + ITER_W'(1);
                if (cnt_reg == ITER_W'(ITER - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= VW'(value);
            res_reg <= '0;
            bit_reg <= VW'(1) << (VW - 2);
        end
        else if (run_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

`default_nettype wire

// File: sv/ssc_cell.sv
// ----------------------------------------------------------------------------
// ssc_cell
// one table entry: holds a primitive and tests each passing sample against it
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_cell import ssc_pkg::*; #(
    parameter int IDX         = 0,
    parameter int SAMPLE_GRID = SAMPLE_GRID_DEF,
    parameter int CW          = 22,
    parameter int PW          = 44
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ssc_wr_t               wr,
    input  wire logic [CNT_W-1:0]      count_eff,
    input  wire ssc_chain_t            chain_in,
    input  wire logic signed [CW-1:0]  x_in,
    input  wire logic signed [CW-1:0]  y_in,
    output ssc_chain_t                 chain_out,
    output logic signed [CW-1:0]       x_out,
    output logic signed [CW-1:0]       y_out
);

    localparam logic signed [CW-1:0] SCALE_S = CW'(2 * SAMPLE_GRID);
    localparam logic signed [CW-1:0] SG_S    = CW'(SAMPLE_GRID);

    // stored entry
    logic [KIND_W-1:0]      kind_reg;
    logic signed [CW-1:0]   ax_reg, ay_reg, bx_reg, by_reg, r_reg, h_reg, len_s_reg;
    logic                   len_zero_reg;
    logic [COL_W-1:0]       colour_reg;
    logic                   derive_reg;
    logic                   hit;

    // derived constants
    logic signed [CW-1:0]   ex_reg, ey_reg;
    logic signed [PW-1:0]   hi2_reg, lo2_reg, r2_reg, hl_reg, elen2_reg;
    logic                   lo_pos_reg;
    logic signed [CW-1:0]   hi, lo;

    // stage a
    ssc_chain_t             chain_a_reg;
    logic signed [CW-1:0]   xa_reg, ya_reg;
    logic signed [PW-1:0]   d2_reg, t_reg, cr_reg;
    logic signed [CW-1:0]   dx, dy, vx, vy;

    // stage b
    ssc_chain_t             chain_b_reg, chain_b_next;
    logic signed [CW-1:0]   xb_reg, yb_reg;
    logic                   active, cov;

    assign hit = wr.valid && (int'(wr.entry_index) == IDX);
    assign hi  = r_reg + h_reg;
    assign lo  = r_reg - h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            derive_reg  <= 1'b0;
            chain_a_reg <= '0;
            chain_b_reg <= '0;
        end
        else
        begin
            derive_reg  <= hit;
            chain_a_reg <= chain_in;
            chain_b_reg <= chain_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            kind_reg     <= wr.shape_kind;
            ax_reg       <= CW'(wr.point_a_x) * SCALE_S;
            ay_reg       <= CW'(wr.point_a_y) * SCALE_S;
            bx_reg       <= CW'(wr.point_b_x) * SCALE_S;
            by_reg       <= CW'(wr.point_b_y) * SCALE_S;
            r_reg        <= $signed(CW'(wr.radius)) * SCALE_S;
            h_reg        <= $signed(CW'(wr.stroke_width)) * SG_S;
            len_s_reg    <= $signed(CW'(wr.length)) * SCALE_S;
            len_zero_reg <= (wr.length == '0);
            colour_reg   <= wr.colour;
        end
        if (derive_reg)
        begin
            ex_reg     <= bx_reg - ax_reg;
            ey_reg     <= by_reg - ay_reg;
            hi2_reg    <= PW'(hi) * PW'(hi);
            lo2_reg    <= PW'(lo) * PW'(lo);
            lo_pos_reg <= (lo > 0);
            r2_reg     <= PW'(r_reg) * PW'(r_reg);
            hl_reg     <= PW'(h_reg) * PW'(len_s_reg);
            elen2_reg  <= PW'(bx_reg - ax_reg) * PW'(bx_reg - ax_reg)
                        + PW'(by_reg - ay_reg) * PW'(by_reg - ay_reg);
        end
    end

    // stage a: distances and products
    assign dx = ax_reg - x_in;
    assign dy = ay_reg - y_in;
    assign vx = x_in - ax_reg;
    assign vy = y_in - ay_reg;

    always_ff @(posedge clk)
    begin
        xa_reg <= x_in;
        ya_reg <= y_in;
        d2_reg <= PW'(dx) * PW'(dx) + PW'(dy) * PW'(dy);
        t_reg  <= PW'(ex_reg) * PW'(vx) + PW'(ey_reg) * PW'(vy);
        cr_reg <= PW'(ex_reg) * PW'(vy) - PW'(ey_reg) * PW'(vx);
    end

    // stage b: coverage decision
    assign active = int'(count_eff) > IDX;

    always_comb
    begin
        cov = 1'b0;
        case (kind_reg)
            KIND_STROKE_CIRCLE:
                cov = !(d2_reg > hi2_reg) && !(lo_pos_reg && (d2_reg < lo2_reg));
            KIND_LINE:
                cov = !len_zero_reg
                    && !(t_reg < -hl_reg)
                    && !((PW+1)'(t_reg) > (PW+1)'(elen2_reg) + (PW+1)'(hl_reg))
                    && !(cr_reg > hl_reg) && !(cr_reg < -hl_reg);
            KIND_STROKE_RECT:
                cov = !(xa_reg <= ax_reg - h_reg || xa_reg >= bx_reg + h_reg
                        || ya_reg <= ay_reg - h_reg || ya_reg >= by_reg + h_reg)
                    && (xa_reg <= ax_reg + h_reg || xa_reg >= bx_reg - h_reg
                        || ya_reg <= ay_reg + h_reg || ya_reg >= by_reg - h_reg);
            KIND_FILL_CIRCLE:
                cov = (d2_reg <= r2_reg);
            KIND_FILL_RECT:
                cov = (xa_reg > ax_reg) && (xa_reg < bx_reg)
                    && (ya_reg > ay_reg) && (ya_reg < by_reg);
            default:
                cov = 1'b0;
        endcase
    end

    always_comb
    begin
        chain_b_next.valid  = chain_a_reg.valid;
        chain_b_next.colour = (active && cov) ? colour_reg : chain_a_reg.colour;
    end

    always_ff @(posedge clk)
    begin
        xb_reg <= xa_reg;
        yb_reg <= ya_reg;
    end

    assign chain_out = chain_b_reg;
    assign x_out     = xb_reg;
    assign y_out     = yb_reg;

endmodule

`default_nettype wire

// File: sv/supersampled_shape_coverage.sv
// ----------------------------------------------------------------------------
// supersampled_shape_coverage
// supersampled coverage of a table of shapes, averaged per pixel
// ----------------------------------------------------------------------------
// A load item writes one table entry: the squared line length is formed, the
// iterative square root takes its rounded root, and the cell stores and
// precomputes the entry. A shade item sends SAMPLE_GRID^2 samples: the
// sequencer sends one sample a cycle into a chain of MAX_PRIMITIVES two-stage
// cells, one per table entry, then a reciprocal multiply averages the four
// channel sums. Items are taken one at a time; a finished result waits in the
// output register while the next item is accepted.
`default_nettype none
`include "supersampled_shape_coverage_macros.svh"

module supersampled_shape_coverage import ssc_pkg::*; #(
    parameter int MAX_PRIMITIVES = MAX_PRIM_DEF,
    parameter int SAMPLE_GRID    = SAMPLE_GRID_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ssc_req_if.sink          req,
    ssc_rsp_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NSMP     = SAMPLE_GRID * SAMPLE_GRID;
    localparam int SCALE_UP = 2 * SAMPLE_GRID;
    localparam int LG       = $clog2(SCALE_UP);
    localparam int CW       = ((16 > 12 + FRAC_BITS) ? 16 : 12 + FRAC_BITS) + LG + 2;
    localparam int PW       = 2 * CW;
    localparam int SG_W     = (SAMPLE_GRID > 1) ? $clog2(SAMPLE_GRID) : 1;
    localparam int NC_W     = $clog2(NSMP + 1);
    localparam int SUM_W    = $clog2(255 * NSMP + 1);
    localparam int DIV_SH   = SUM_W + $clog2(NSMP);
    localparam longint RECIP = ((longint'(1) << DIV_SH) + longint'(NSMP) - 1)
                             / longint'(NSMP);
    localparam int RCP_W    = DIV_SH + 1;
    localparam int PRD_W    = SUM_W + RCP_W;
    localparam logic [1:0] COUNT_ADDR = 2'd0;

    ssc_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_eff;

    ssc_wr_t            load_reg, wr;
    logic [PIX_W-1:0]   px_reg, py_reg;
    logic [SG_W-1:0]    sx_reg, sy_reg;
    logic [NC_W-1:0]    issue_cnt_reg, exit_cnt_reg;
    logic [SUM_W-1:0]   sum_reg [4];
    logic [7:0]         q_reg [4];
    logic               out_valid_reg;
    logic [PIX_W-1:0]   ox_reg, oy_reg;
    logic [7:0]         ob_reg, og_reg, or_reg, oa_reg;

    logic               accept, sq_start, sq_done, issue, out_load;
    logic [LEN_W-1:0]   root;
    logic signed [16:0] ddx, ddy;
    logic signed [SQ_W-1:0] sqsum;
    logic [CW-1:0]      spx_u, spy_u;
    logic [PRD_W-1:0]   prod [4];

    ssc_chain_t           chain [MAX_PRIMITIVES+1];
    logic signed [CW-1:0] cx [MAX_PRIMITIVES+1];
    logic signed [CW-1:0] cy [MAX_PRIMITIVES+1];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == COUNT_ADDR) ? 32'(count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (psel && penable && pwrite)
            count_reg <= pwdata[CNT_W-1:0];
    end

    always_comb
    begin
        count_eff = count_reg;
        if (int'(count_reg) > MAX_PRIMITIVES)
            count_eff = CNT_W'(MAX_PRIMITIVES);
        if (int'(count_eff) > TABLE_SLOTS)
            count_eff = CNT_W'(TABLE_SLOTS);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (req.valid)
                    state_next = (req.command == CMD_SHADE) ? ST_SHADE : ST_LOAD_SQ;
            ST_LOAD_SQ:
                state_next = ST_LOAD_ROOT;
            ST_LOAD_ROOT:
                if (sq_done)
                    state_next = ST_LOAD_WAIT;
            ST_LOAD_WAIT:
                state_next = ST_IDLE;
            ST_SHADE:
                if (exit_cnt_reg == NC_W'(NSMP))
                    state_next = ST_DIV;
            ST_DIV:
                state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || rsp.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        sq_start  = 1'b0;
        issue     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:      req.ready = 1'b1;
            ST_LOAD_SQ:   sq_start  = 1'b1;
            ST_SHADE:     issue     = (issue_cnt_reg < NC_W'(NSMP));
            ST_OUT:       out_load  = !out_valid_reg || rsp.ready;
            default:      ;
        endcase
    end

    assign accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
            exit_cnt_reg  <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                issue_cnt_reg <= '0;
                exit_cnt_reg  <= '0;
                sx_reg        <= '0;
                sy_reg        <= '0;
            end
            else
            begin
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + NC_W'(1);
                    if (sx_reg == SG_W'(SAMPLE_GRID - 1))
                    begin
                        sx_reg <= '0;
                        sy_reg <= sy_reg + SG_W'(1);
                    end
                    else
                    begin
                        sx_reg <= sx_reg + SG_W'(1);
                    end
                end
                if (chain[MAX_PRIMITIVES].valid)
                    exit_cnt_reg <= exit_cnt_reg + NC_W'(1);
            end
        end
    end

    // load path
    assign ddx   = 17'(load_reg.point_b_x) - 17'(load_reg.point_a_x);
    assign ddy   = 17'(load_reg.point_b_y) - 17'(load_reg.point_a_y);
    assign sqsum = SQ_W'(ddx) * SQ_W'(ddx) + SQ_W'(ddy) * SQ_W'(ddy);

    ssc_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value ($unsigned(sqsum)),
        .done  (sq_done),
        .root  (root)
    );

    always_comb
    begin
        wr        = load_reg;
        wr.valid  = (state_reg == ST_LOAD_ROOT) && sq_done;
        wr.length = root;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            load_reg.valid        <= 1'b0;
            load_reg.entry_index  <= req.entry_index;
            load_reg.shape_kind   <= req.shape_kind;
            load_reg.point_a_x    <= req.point_a_x;
            load_reg.point_a_y    <= req.point_a_y;
            load_reg.point_b_x    <= req.point_b_x;
            load_reg.point_b_y    <= req.point_b_y;
            load_reg.radius       <= req.radius;
            load_reg.stroke_width <= req.stroke_width;
            load_reg.colour       <= req.colour;
            load_reg.length       <= '0;
            px_reg                <= req.pixel_x;
            py_reg                <= req.pixel_y;
        end
    end

    // sample positions
    assign spx_u = ((CW'(px_reg) * CW'(SCALE_UP)) + (CW'(sx_reg) << 1) + CW'(1)) << FRAC_BITS;
    assign spy_u = ((CW'(py_reg) * CW'(SCALE_UP)) + (CW'(sy_reg) << 1) + CW'(1)) << FRAC_BITS;

    assign chain[0] = {issue, COL_W'(0)};
    assign cx[0]    = $signed(spx_u);
    assign cy[0]    = $signed(spy_u);

    for (genvar i = 0; i < MAX_PRIMITIVES; i++)
    begin : g_cell
        ssc_cell #(
            .IDX         (i),
            .SAMPLE_GRID (SAMPLE_GRID),
            .CW          (CW),
            .PW          (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .count_eff (count_eff),
            .chain_in  (chain[i]),
            .x_in      (cx[i]),
            .y_in      (cy[i]),
            .chain_out (chain[i+1]),
            .x_out     (cx[i+1]),
            .y_out     (cy[i+1])
        );
    end

    // channel sums and averaging, channel c is colour byte c (alpha first)
    // floor of sum over sample count by a reciprocal multiply
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            prod[c] = PRD_W'(sum_reg[c]) * PRD_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (accept)
                sum_reg[c] <= '0;
            else if (state_reg == ST_SHADE && chain[MAX_PRIMITIVES].valid)
                sum_reg[c] <= sum_reg[c] + SUM_W'(chain[MAX_PRIMITIVES].colour[c*8 +: 8]);
            else if (state_reg == ST_DIV)
                q_reg[c] <= prod[c][DIV_SH +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ox_reg <= px_reg;
            oy_reg <= py_reg;
            oa_reg <= q_reg[0];
            ob_reg <= q_reg[1];
            og_reg <= q_reg[2];
            or_reg <= q_reg[3];
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.out_x = ox_reg;
    assign rsp.out_y = oy_reg;
    assign rsp.blue  = ob_reg;
    assign rsp.green = og_reg;
    assign rsp.red   = or_reg;
    assign rsp.alpha = oa_reg;

    `SSC_ASSERT_IMP(a_tail_in_shade, clk, rst_n, chain[MAX_PRIMITIVES].valid, state_reg == ST_SHADE)
    `SSC_ASSERT_IMP(a_exit_le_issue, clk, rst_n, 1'b1, exit_cnt_reg <= issue_cnt_reg)
    `SSC_ASSERT_IMP(a_root_in_load, clk, rst_n, sq_done, state_reg == ST_LOAD_ROOT)
    `SSC_ASSERT_NXT(a_out_after_div, clk, rst_n, state_reg == ST_DIV, state_reg == ST_OUT)

endmodule

`default_nettype wire

// File: tb/tb_supersampled_shape_coverage.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_supersampled_shape_coverage
// Self-checking bench for the supersampled shape coverage block. Loads
// tables of circles, lines and rectangles and shades pixels against them.
// Every averaged pixel is checked against a local integer model of the
// 8x8 sample grid. Random gaps on both sides and one long output stall are
// applied, and the primitive count is swept through its range.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_supersampled_shape_coverage;
    import ssc_pkg::*;

    localparam int GRID = 8;
    localparam int UPSCALE = 2 * GRID;
    localparam int SETTLE = 200;

    typedef struct {
        logic                   command;
        logic [IDX_W-1:0]       entry_index;
        logic [KIND_W-1:0]      shape_kind;
        logic signed [PT_W-1:0] ax, ay, bx, by;
        logic [PT_W-1:0]        radius;
        logic [PT_W-1:0]        stroke;
        logic [COL_W-1:0]       colour;
        logic [PIX_W-1:0]       px, py;
    } cmd_t;

    typedef struct {
        logic [PIX_W-1:0] x, y;
        logic [7:0]       b, g, r, a;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ssc_req_if req();
    ssc_rsp_if rsp();

    supersampled_shape_coverage dut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // local copy of the shape table
    logic [KIND_W-1:0]      tbl_kind [TABLE_SLOTS];
    logic signed [PT_W-1:0] tbl_ax [TABLE_SLOTS];
    logic signed [PT_W-1:0] tbl_ay [TABLE_SLOTS];
    logic signed [PT_W-1:0] tbl_bx [TABLE_SLOTS];
    logic signed [PT_W-1:0] tbl_by [TABLE_SLOTS];
    logic [PT_W-1:0]        tbl_rad [TABLE_SLOTS];
    logic [PT_W-1:0]        tbl_wid [TABLE_SLOTS];
    logic [COL_W-1:0]       tbl_col [TABLE_SLOTS];
    logic [LEN_W-1:0]       tbl_len [TABLE_SLOTS];
    logic [CNT_W-1:0]       shape_count = '0;

    pixel_t pending_pixels[$];
    int     errors = 0;
    int     hold_cycles = 0;
    bit     no_idle = 0;

    function automatic longint unsigned round_sqrt(longint unsigned v);
        longint unsigned res, bitv, n;
        res = 0;
        bitv = 64'd1 << 62;
        n = v;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else res >>= 1;
            bitv >>= 2;
        end
        if (v > res * res + res) res++;
        return res;
    endfunction

    function automatic bit sample_hit(int e, longint sx, longint sy);
        longint ax, ay, bx, by, r, h, dx, dy, d2, hi, lo, ex, ey, vx, vy, hl, t, cr;
        ax = longint'(tbl_ax[e]) * UPSCALE;
        ay = longint'(tbl_ay[e]) * UPSCALE;
        bx = longint'(tbl_bx[e]) * UPSCALE;
        by = longint'(tbl_by[e]) * UPSCALE;
        r = longint'(tbl_rad[e]) * UPSCALE;
        h = longint'(tbl_wid[e]) * GRID;
        dx = ax - sx;
        dy = ay - sy;
        d2 = dx * dx + dy * dy;
        case (tbl_kind[e])
            KIND_STROKE_CIRCLE:
            begin
                hi = r + h;
                lo = r - h;
                if (d2 > hi * hi) return 0;
                if (lo > 0 && d2 < lo * lo) return 0;
                return 1;
            end
            KIND_LINE:
            begin
                if (tbl_len[e] == 0) return 0;
                ex = bx - ax;
                ey = by - ay;
                vx = sx - ax;
                vy = sy - ay;
                hl = h * (longint'(tbl_len[e]) * UPSCALE);
                t = ex * vx + ey * vy;
                if (t < -hl) return 0;
                if (t > ex * ex + ey * ey + hl) return 0;
                cr = ex * vy - ey * vx;
                if (cr > hl || cr < -hl) return 0;
                return 1;
            end
            KIND_STROKE_RECT:
            begin
                if (sx <= ax - h || sx >= bx + h || sy <= ay - h || sy >= by + h) return 0;
                if (!(sx <= ax + h || sx >= bx - h || sy <= ay + h || sy >= by - h))
                    return 0;
                return 1;
            end
            KIND_FILL_CIRCLE: return d2 <= r * r;
            KIND_FILL_RECT: return sx > ax && sx < bx && sy > ay && sy < by;
            default: return 0;
        endcase
    endfunction

    function automatic pixel_t average_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        pixel_t p;
        longint sx, sy;
        longint unsigned sr, sg, sb, sa;
        logic [COL_W-1:0] c;
        int n;
        n = (shape_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(shape_count);
        sr = 0; sg = 0; sb = 0; sa = 0;
        for (int j = 0; j < GRID; j++) begin
            sy = longint'(py) * 16 * UPSCALE + longint'(2 * j + 1) * 16;
            for (int i = 0; i < GRID; i++) begin
                sx = longint'(px) * 16 * UPSCALE + longint'(2 * i + 1) * 16;
                c = '0;
                for (int e = 0; e < n; e++)
                    if (sample_hit(e, sx, sy)) c = tbl_col[e];
                sr += c[31:24];
                sg += c[23:16];
                sb += c[15:8];
                sa += c[7:0];
            end
        end
        p.x = px;
        p.y = py;
        p.b = 8'(sb / (GRID * GRID));
        p.g = 8'(sg / (GRID * GRID));
        p.r = 8'(sr / (GRID * GRID));
        p.a = 8'(sa / (GRID * GRID));
        return p;
    endfunction

    function automatic void store_entry(cmd_t c);
        longint ddx, ddy;
        int i;
        i = c.entry_index;
        tbl_kind[i] = c.shape_kind;
        tbl_ax[i] = c.ax;
        tbl_ay[i] = c.ay;
        tbl_bx[i] = c.bx;
        tbl_by[i] = c.by;
        tbl_rad[i] = c.radius;
        tbl_wid[i] = c.stroke;
        tbl_col[i] = c.colour;
        ddx = longint'(c.bx) - longint'(c.ax);
        ddy = longint'(c.by) - longint'(c.ay);
        tbl_len[i] = LEN_W'(round_sqrt(longint'(ddx * ddx + ddy * ddy)));
    endfunction

    function automatic int idle_len();
        int k;
        if (no_idle) return 0;
        k = $urandom_range(99);
        if (k < 60) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sends one item and records what it should produce
    task automatic send_item(cmd_t c);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid <= 1'b1;
        req.command <= c.command;
        req.entry_index <= c.entry_index;
        req.shape_kind <= c.shape_kind;
        req.point_a_x <= c.ax;
        req.point_a_y <= c.ay;
        req.point_b_x <= c.bx;
        req.point_b_y <= c.by;
        req.radius <= c.radius;
        req.stroke_width <= c.stroke;
        req.colour <= c.colour;
        req.pixel_x <= c.px;
        req.pixel_y <= c.py;
        do @(posedge clk); while (!req.ready);
        if (c.command == CMD_LOAD) store_entry(c);
        else pending_pixels.insert(pending_pixels.size(), average_pixel(c.px, c.py));
    endtask

    task automatic release_bus();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic drain();
        release_bus();
        wait (pending_pixels.size() == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {$urandom} & ~32'h1f | 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        shape_count = v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CNT_W-1:0] !== v) report_mismatch("primitive_count", prdata[CNT_W-1:0], v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic cmd_t random_fields();
        cmd_t c;
        c.command = 1'($urandom_range(1));
        c.entry_index = IDX_W'($urandom);
        c.shape_kind = KIND_W'($urandom);
        c.ax = PT_W'($urandom);
        c.ay = PT_W'($urandom);
        c.bx = PT_W'($urandom);
        c.by = PT_W'($urandom);
        c.radius = PT_W'($urandom);
        c.stroke = PT_W'($urandom);
        c.colour = $urandom;
        c.px = PIX_W'($urandom);
        c.py = PIX_W'($urandom);
        return c;
    endfunction

    function automatic cmd_t make_load(int idx, logic [KIND_W-1:0] k, int ax, int ay, int bx,
                                       int by, int rad, int wid);
        cmd_t c;
        c = random_fields();
        c.command = CMD_LOAD;
        c.entry_index = IDX_W'(idx);
        c.shape_kind = k;
        c.ax = PT_W'(ax);
        c.ay = PT_W'(ay);
        c.bx = PT_W'(bx);
        c.by = PT_W'(by);
        c.radius = PT_W'(rad);
        c.stroke = PT_W'(wid);
        return c;
    endfunction

    function automatic cmd_t make_shade(int px, int py);
        cmd_t c;
        c = random_fields();
        c.command = CMD_SHADE;
        c.px = PIX_W'(px);
        c.py = PIX_W'(py);
        return c;
    endfunction

    // shapes placed around the first few pixels so samples land on edges
    function automatic cmd_t random_shape_load();
        cmd_t c;
        int k;
        c = random_fields();
        c.command = CMD_LOAD;
        if ($urandom_range(9) == 0) return c;
        k = $urandom_range(19);
        c.shape_kind = KIND_W'((k < 18) ? k % 5 : int'($urandom_range(5, 7)));
        c.ax = PT_W'($urandom_range(0, 160) - 16);
        c.ay = PT_W'($urandom_range(0, 160) - 16);
        c.bx = PT_W'((c.shape_kind == KIND_LINE) ? $urandom_range(0, 160) - 16
                                                 : c.ax + $urandom_range(0, 96));
        c.by = PT_W'((c.shape_kind == KIND_LINE) ? $urandom_range(0, 160) - 16
                                                 : c.ay + $urandom_range(0, 96));
        if ($urandom_range(15) == 0) begin
            c.bx = c.ax;
            c.by = c.ay;
        end
        c.radius = PT_W'($urandom_range(0, 80));
        c.stroke = PT_W'($urandom_range(0, 40));
        return c;
    endfunction

    function automatic cmd_t random_shade();
        if ($urandom_range(9) == 0) return make_shade($urandom, $urandom);
        return make_shade($urandom_range(0, 9), $urandom_range(0, 9));
    endfunction

    task automatic test_table_fill();
        send_item(make_load(0, KIND_FILL_RECT, -32768, -32768, 32767, 32767, 0, 0));
        send_item(make_load(1, KIND_FILL_CIRCLE, 40, 40, 0, 0, 24, 0));
        send_item(make_load(2, KIND_STROKE_CIRCLE, 64, 64, 0, 0, 32, 8));
        send_item(make_load(3, KIND_STROKE_CIRCLE, 16, 16, 0, 0, 0, 65535));
        send_item(make_load(4, KIND_LINE, 0, 0, 128, 64, 0, 6));
        send_item(make_load(5, KIND_LINE, 32, 32, 32, 32, 0, 65535));
        send_item(make_load(6, KIND_STROKE_RECT, 16, 16, 80, 80, 0, 4));
        send_item(make_load(7, KIND_FILL_RECT, 16, 16, 32, 32, 0, 0));
        send_item(make_load(8, 3'd5, 0, 0, 64, 64, 65535, 65535));
        send_item(make_load(9, 3'd7, 0, 0, 64, 64, 65535, 65535));
        send_item(make_load(10, KIND_LINE, -32768, -32768, 32767, 32767, 0, 1));
        send_item(make_load(11, KIND_FILL_CIRCLE, 32767, 32767, 0, 0, 65535, 0));
        send_item(make_load(12, KIND_STROKE_RECT, 0, 0, 16, 16, 0, 0));
        send_item(make_load(13, KIND_FILL_CIRCLE, 8, 8, 0, 0, 0, 0));
        send_item(make_load(14, KIND_LINE, 8, 0, 8, 48, 0, 0));
        send_item(make_load(15, KIND_FILL_RECT, 24, 8, 24, 40, 0, 0));
        drain();
    endtask

    task automatic test_count_sweep();
        logic [CNT_W-1:0] counts [6] = '{5'd0, 5'd1, 5'd8, 5'd16, 5'd17, 5'd31};
        foreach (counts[i]) begin
            write_count(counts[i]);
            send_item(make_shade(0, 0));
            send_item(make_shade(1, 1));
            send_item(make_shade(2047, 2047));
            send_item(make_shade(3, 2));
            drain();
        end
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 14; phase++) begin
            no_idle = (phase % 4 == 3);
            write_count((phase % 5 == 0) ? 5'd16 : CNT_W'($urandom_range(0, 31)));
            for (int n = 0; n < 100; n++)
                send_item(($urandom_range(2) == 0) ? random_shape_load() : random_shade());
            drain();
        end
        no_idle = 0;
    endtask

    task automatic test_output_stall();
        write_count(5'd16);
        hold_cycles = 800;
        for (int n = 0; n < 12; n++) send_item(random_shade());
        drain();
    endtask

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else if (no_idle) rsp.ready <= 1'b1;
        else rsp.ready <= ($urandom_range(9) < 7) || ($urandom_range(19) == 0);
    end

    always @(posedge clk) begin
        pixel_t want;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", 1, 0);
            end
            else begin
                want = pending_pixels.pop_front();
                if (rsp.out_x !== want.x) report_mismatch("out_x", rsp.out_x, want.x);
                if (rsp.out_y !== want.y) report_mismatch("out_y", rsp.out_y, want.y);
                if (rsp.blue !== want.b) report_mismatch("blue", rsp.blue, want.b);
                if (rsp.green !== want.g) report_mismatch("green", rsp.green, want.g);
                if (rsp.red !== want.r) report_mismatch("red", rsp.red, want.r);
                if (rsp.alpha !== want.a) report_mismatch("alpha", rsp.alpha, want.a);
            end
        end
    end

    initial begin
        req.valid = 1'b0;
        req.command = CMD_LOAD;
        req.entry_index = '0;
        req.shape_kind = '0;
        req.point_a_x = '0;
        req.point_a_y = '0;
        req.point_b_x = '0;
        req.point_b_y = '0;
        req.radius = '0;
        req.stroke_width = '0;
        req.colour = '0;
        req.pixel_x = '0;
        req.pixel_y = '0;
        rsp.ready = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_table_fill();
        test_count_sweep();
        test_random_mix();
        test_output_stall();
        if (pending_pixels.size() != 0)
            report_mismatch("pending pixels", pending_pixels.size(), 0);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
